// ===== sv/blob_box_and_slope_extractor_unit_assert.svh =====
// Assertion macros shared by the blob box and slope extractor RTL.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef BLOB_BOX_AND_SLOPE_EXTRACTOR_UNIT_ASSERT_SVH
`define BLOB_BOX_AND_SLOPE_EXTRACTOR_UNIT_ASSERT_SVH

// property checked on every rising clock edge outside reset
`define BBSE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition that must never be true outside reset
`define BBSE_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== sv/bbse_pkg.sv =====
// Shared types and constants of the blob box and slope extractor.
// No dependencies.
package bbse_pkg;

  localparam int unsigned CoordBits = 12;
  localparam int unsigned CountBits = 16;
  localparam logic [CountBits-1:0] MaxPoints = 16'hFFFF;
  localparam int unsigned SumBits   = 28;
  localparam int unsigned SqBits    = 40;
  localparam int unsigned ProdBits  = 56;
  localparam int unsigned NumBits   = 72;
  localparam int unsigned QuotBits  = 44;
  localparam int unsigned ScaleBits = 23;
  localparam int unsigned DimBits   = 13;
  localparam int unsigned NdBits    = 28;

  // one closed region as handed from front to back
  typedef struct packed {
    logic [CoordBits-1:0] left;
    logic [CoordBits-1:0] right;
    logic [CoordBits-1:0] top;
    logic [CoordBits-1:0] bottom;
    logic [CountBits-1:0] cnt;
    logic [SumBits-1:0]   sx;
    logic [SumBits-1:0]   sy;
    logic [SqBits-1:0]    sxx;
    logic [SqBits-1:0]    sxy;
    logic                 ovf;
  } region_t;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_MUL1  = 9'b000000010,
    S_MUL2  = 9'b000000100,
    S_MUL3  = 9'b000001000,
    S_DIVS  = 9'b000010000,
    S_WDIV  = 9'b000100000,
    S_WSQ   = 9'b001000000,
    S_HDIV  = 9'b010000000,
    S_HSQ   = 9'b100000000
  } back_state_e;

endpackage

// ===== sv/bbse_front.sv =====
// Front end: accumulates box, count and sums one point per cycle.
// Depends on bbse_pkg.
module bbse_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            acc_i,
  input  logic [bbse_pkg::CoordBits-1:0]  x_i,
  input  logic [bbse_pkg::CoordBits-1:0]  y_i,
  input  logic                            last_i,
  output logic                            push_o,
  output bbse_pkg::region_t               region_o
);

  logic [bbse_pkg::CountBits-1:0] cnt_q, cnt_d;
  logic [bbse_pkg::SumBits-1:0]   sx_q, sx_d, sy_q, sy_d;
  logic [bbse_pkg::SqBits-1:0]    sxx_q, sxx_d, sxy_q, sxy_d;
  logic                           ovf_q, ovf_d;
  logic [bbse_pkg::CoordBits-1:0] minx_q, minx_d, maxx_q, maxx_d;
  logic [bbse_pkg::CoordBits-1:0] miny_q, miny_d, maxy_q, maxy_d;
  logic                           first;

  assign first = (cnt_q == '0);

  always_comb begin
    cnt_d  = cnt_q;
    sx_d   = sx_q;
    sy_d   = sy_q;
    sxx_d  = sxx_q;
    sxy_d  = sxy_q;
    ovf_d  = ovf_q;
    minx_d = minx_q;
    maxx_d = maxx_q;
    miny_d = miny_q;
    maxy_d = maxy_q;
    if (acc_i) begin
      if (cnt_q == bbse_pkg::MaxPoints) begin
        ovf_d = 1'b1;
      end else begin
        minx_d = (first || x_i < minx_q) ? x_i : minx_q;
        maxx_d = (first || x_i > maxx_q) ? x_i : maxx_q;
        miny_d = (first || y_i < miny_q) ? y_i : miny_q;
        maxy_d = (first || y_i > maxy_q) ? y_i : maxy_q;
        cnt_d  = cnt_q + 1'b1;
        sx_d   = sx_q + bbse_pkg::SumBits'(x_i);
        sy_d   = sy_q + bbse_pkg::SumBits'(y_i);
        sxx_d  = sxx_q + bbse_pkg::SqBits'(x_i) * bbse_pkg::SqBits'(x_i);
        sxy_d  = sxy_q + bbse_pkg::SqBits'(x_i) * bbse_pkg::SqBits'(y_i);
      end
    end
  end

  assign push_o = acc_i & last_i;

  always_comb begin
    region_o.left   = minx_d;
    region_o.right  = maxx_d;
    region_o.top    = miny_d;
    region_o.bottom = maxy_d;
    region_o.cnt    = cnt_d;
    region_o.sx     = sx_d;
    region_o.sy     = sy_d;
    region_o.sxx    = sxx_d;
    region_o.sxy    = sxy_d;
    region_o.ovf    = ovf_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      sx_q  <= '0;
      sy_q  <= '0;
      sxx_q <= '0;
      sxy_q <= '0;
      ovf_q <= 1'b0;
    end else if (push_o) begin
      cnt_q <= '0;
      sx_q  <= '0;
      sy_q  <= '0;
      sxx_q <= '0;
      sxy_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      sx_q  <= sx_d;
      sy_q  <= sy_d;
      sxx_q <= sxx_d;
      sxy_q <= sxy_d;
      ovf_q <= ovf_d;
    end
  end

  // box is reloaded by the first point of a region
  always_ff @(posedge clk_i) begin
    minx_q <= minx_d;
    maxx_q <= maxx_d;
    miny_q <= miny_d;
    maxy_q <= maxy_d;
  end

endmodule

// ===== sv/bbse_queue.sv =====
// Two-entry region queue between front and back.
// Depends on bbse_pkg and the assertion header.
`include "blob_box_and_slope_extractor_unit_assert.svh"
module bbse_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  bbse_pkg::region_t data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              avail_o,
  output bbse_pkg::region_t data_o
);

  bbse_pkg::region_t ent_q [2];
  logic [1:0] cnt_q;
  logic       wr_q, rd_q;

  assign full_o  = (cnt_q == 2'd2);
  assign avail_o = (cnt_q != 2'd0);
  assign data_o  = ent_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) ent_q[wr_q] <= data_i;
  end

  `BBSE_NEVER(a_q_overrun, push_i && full_o && !pop_i, "queue push while full")
  `BBSE_NEVER(a_q_underrun, pop_i && !avail_o, "queue pop while empty")
  `BBSE_NEVER(a_q_count, cnt_q == 2'd3, "queue count out of range")

endmodule

// ===== sv/bbse_div.sv =====
// Restoring divider, one quotient bit per cycle over a 72-bit numerator.
// Depends on bbse_pkg.
module bbse_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [bbse_pkg::NumBits-1:0]   num_i,
  input  logic [bbse_pkg::ProdBits-1:0]  den_i,
  output logic                           done_o,
  output logic [bbse_pkg::QuotBits-1:0]  quot_o,
  output logic                           big_o
);

  logic [bbse_pkg::NumBits-1:0]  num_q;
  logic [bbse_pkg::ProdBits-1:0] den_q, rem_q;
  logic [bbse_pkg::ProdBits:0]   rem_sh, rem_sub;
  logic [bbse_pkg::QuotBits-1:0] quot_q;
  logic                          big_q, busy_q, done_q, ge;
  logic [6:0]                    it_q;

  assign rem_sh  = {rem_q, num_q[bbse_pkg::NumBits-1]};
  assign rem_sub = rem_sh - {1'b0, den_q};
  assign ge      = (rem_sh >= {1'b0, den_q});
  assign done_o  = done_q;
  assign quot_o  = quot_q;
  assign big_o   = big_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      it_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        it_q   <= 7'(bbse_pkg::NumBits - 1);
      end else if (busy_q) begin
        it_q <= it_q - 1'b1;
        if (it_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q  <= num_i;
      den_q  <= den_i;
      rem_q  <= '0;
      quot_q <= '0;
      big_q  <= 1'b0;
    end else if (busy_q) begin
      num_q  <= {num_q[bbse_pkg::NumBits-2:0], 1'b0};
      rem_q  <= ge ? rem_sub[bbse_pkg::ProdBits-1:0] : rem_sh[bbse_pkg::ProdBits-1:0];
      quot_q <= {quot_q[bbse_pkg::QuotBits-2:0], ge};
      big_q  <= big_q | quot_q[bbse_pkg::QuotBits-1];
    end
  end

endmodule

// ===== sv/bbse_sqrt.sv =====
// Digit-by-digit integer square root of a 44-bit value, one digit per cycle.
// Depends on bbse_pkg.
module bbse_sqrt (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [bbse_pkg::QuotBits-1:0]  val_i,
  output logic                           done_o,
  output logic [bbse_pkg::ScaleBits-1:0] root_o
);

  logic [bbse_pkg::QuotBits-1:0] v_q, r_q, b_q, rb;
  logic                          busy_q, done_q;
  logic [4:0]                    it_q;

  assign rb     = r_q + b_q;
  assign done_o = done_q;
  // root stays below 2^22; clamp kept for the Q15.8 range
  assign root_o = (|r_q[bbse_pkg::QuotBits-1:bbse_pkg::ScaleBits]) ? '1
                : r_q[bbse_pkg::ScaleBits-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      it_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        it_q   <= 5'(bbse_pkg::QuotBits / 2 - 1);
      end else if (busy_q) begin
        it_q <= it_q - 1'b1;
        if (it_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q <= val_i;
      r_q <= '0;
      b_q <= {2'b01, {(bbse_pkg::QuotBits-2){1'b0}}};
    end else if (busy_q) begin
      if (v_q >= rb) begin
        v_q <= v_q - rb;
        r_q <= (r_q >> 1) + b_q;
      end else begin
        r_q <= r_q >> 1;
      end
      b_q <= b_q >> 2;
    end
  end

endmodule

// ===== sv/bbse_back.sv =====
// Back end: per-region sequencer for slope and scaled box size.
// Depends on bbse_pkg, bbse_div, bbse_sqrt and the assertion header.
`include "blob_box_and_slope_extractor_unit_assert.svh"
module bbse_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            avail_i,
  input  bbse_pkg::region_t               region_i,
  output logic                            pop_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [bbse_pkg::CoordBits-1:0]  left_o,
  output logic [bbse_pkg::CoordBits-1:0]  right_o,
  output logic [bbse_pkg::CoordBits-1:0]  top_o,
  output logic [bbse_pkg::CoordBits-1:0]  bottom_o,
  output logic [bbse_pkg::ScaleBits-1:0]  scaled_width_o,
  output logic [bbse_pkg::ScaleBits-1:0]  scaled_height_o,
  output logic [31:0]                     slope_o,
  output logic                            slope_valid_o,
  output logic [bbse_pkg::CountBits-1:0]  point_count_o,
  output logic                            overflow_o
);

  bbse_pkg::back_state_e state_q, state_d;
  bbse_pkg::region_t     rec_q;
  logic                  out_valid_q, out_load;

  logic [bbse_pkg::ProdBits-1:0] p1_q, p2_q, mag_q, den;
  logic                          neg_q, den_nz;
  logic [bbse_pkg::DimBits-1:0]  w_q, h_q;
  logic [bbse_pkg::NdBits-1:0]   nw_q, nh_q;

  logic [31:0]                    slope_q, slope_d, qmag;
  logic                           sval_q;
  logic [bbse_pkg::ScaleBits-1:0] sw_q, sh_q;
  logic                           sat;

  logic                           div_start, div_done, div_big;
  logic [bbse_pkg::NumBits-1:0]   div_num;
  logic [bbse_pkg::ProdBits-1:0]  div_den;
  logic [bbse_pkg::QuotBits-1:0]  div_q;
  logic                           sq_start, sq_done;
  logic [bbse_pkg::ScaleBits-1:0] sq_root;

  assign den    = (p1_q >= p2_q) ? (p1_q - p2_q) : '0;
  assign den_nz = (den != '0);

  // saturate the quotient magnitude to the signed Q16.16 range
  always_comb begin
    if (neg_q) begin
      sat  = div_big | (|div_q[bbse_pkg::QuotBits-1:32]) | (div_q[31] & (|div_q[30:0]));
      qmag = sat ? 32'h8000_0000 : div_q[31:0];
      slope_d = 32'd0 - qmag;
    end else begin
      sat  = div_big | (|div_q[bbse_pkg::QuotBits-1:31]);
      qmag = sat ? 32'h7FFF_FFFF : div_q[31:0];
      slope_d = qmag;
    end
  end

  always_comb begin
    state_d   = state_q;
    pop_o     = 1'b0;
    div_start = 1'b0;
    sq_start  = 1'b0;
    out_load  = 1'b0;
    div_num   = {bbse_pkg::ProdBits'(nh_q), 16'h0000};
    div_den   = bbse_pkg::ProdBits'(w_q);
    case (state_q)
      bbse_pkg::S_IDLE: begin
        if (avail_i && !out_valid_q) begin
          pop_o   = 1'b1;
          state_d = bbse_pkg::S_MUL1;
        end
      end
      bbse_pkg::S_MUL1: state_d = bbse_pkg::S_MUL2;
      bbse_pkg::S_MUL2: state_d = bbse_pkg::S_MUL3;
      bbse_pkg::S_MUL3: begin
        div_start = 1'b1;
        if (den_nz) begin
          div_num = {mag_q, 16'h0000};
          div_den = den;
          state_d = bbse_pkg::S_DIVS;
        end else begin
          div_num = {bbse_pkg::ProdBits'(nw_q), 16'h0000};
          div_den = bbse_pkg::ProdBits'(h_q);
          state_d = bbse_pkg::S_WDIV;
        end
      end
      bbse_pkg::S_DIVS: begin
        if (div_done) begin
          div_start = 1'b1;
          div_num   = {bbse_pkg::ProdBits'(nw_q), 16'h0000};
          div_den   = bbse_pkg::ProdBits'(h_q);
          state_d   = bbse_pkg::S_WDIV;
        end
      end
      bbse_pkg::S_WDIV: begin
        if (div_done) begin
          sq_start = 1'b1;
          state_d  = bbse_pkg::S_WSQ;
        end
      end
      bbse_pkg::S_WSQ: begin
        if (sq_done) begin
          div_start = 1'b1;
          state_d   = bbse_pkg::S_HDIV;
        end
      end
      bbse_pkg::S_HDIV: begin
        if (div_done) begin
          sq_start = 1'b1;
          state_d  = bbse_pkg::S_HSQ;
        end
      end
      bbse_pkg::S_HSQ: begin
        if (sq_done) begin
          out_load = 1'b1;
          state_d  = bbse_pkg::S_IDLE;
        end
      end
      default: state_d = bbse_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bbse_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) rec_q <= region_i;
    case (state_q)
      bbse_pkg::S_MUL1: begin
        p1_q <= bbse_pkg::ProdBits'(rec_q.cnt) * bbse_pkg::ProdBits'(rec_q.sxy);
        p2_q <= bbse_pkg::ProdBits'(rec_q.sx) * bbse_pkg::ProdBits'(rec_q.sy);
        w_q  <= bbse_pkg::DimBits'(rec_q.right) - bbse_pkg::DimBits'(rec_q.left) + 1'b1;
        h_q  <= bbse_pkg::DimBits'(rec_q.bottom) - bbse_pkg::DimBits'(rec_q.top) + 1'b1;
      end
      bbse_pkg::S_MUL2: begin
        neg_q <= (p1_q < p2_q);
        mag_q <= (p1_q < p2_q) ? (p2_q - p1_q) : (p1_q - p2_q);
        p1_q  <= bbse_pkg::ProdBits'(rec_q.cnt) * bbse_pkg::ProdBits'(rec_q.sxx);
        p2_q  <= bbse_pkg::ProdBits'(rec_q.sx) * bbse_pkg::ProdBits'(rec_q.sx);
        nw_q  <= bbse_pkg::NdBits'(rec_q.cnt) * bbse_pkg::NdBits'(w_q);
        nh_q  <= bbse_pkg::NdBits'(rec_q.cnt) * bbse_pkg::NdBits'(h_q);
      end
      bbse_pkg::S_MUL3: begin
        sval_q  <= den_nz;
        slope_q <= '0;
      end
      bbse_pkg::S_DIVS: begin
        if (div_done) slope_q <= slope_d;
      end
      bbse_pkg::S_WSQ: begin
        if (sq_done) sw_q <= sq_root;
      end
      bbse_pkg::S_HSQ: begin
        if (sq_done) sh_q <= sq_root;
      end
      default: ;
    endcase
  end

  bbse_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_q),
    .big_o   (div_big)
  );

  bbse_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .val_i   (div_q),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  assign out_valid_o     = out_valid_q;
  assign left_o          = rec_q.left;
  assign right_o         = rec_q.right;
  assign top_o           = rec_q.top;
  assign bottom_o        = rec_q.bottom;
  assign scaled_width_o  = sw_q;
  assign scaled_height_o = sh_q;
  assign slope_o         = slope_q;
  assign slope_valid_o   = sval_q;
  assign point_count_o   = rec_q.cnt;
  assign overflow_o      = rec_q.ovf;

  `BBSE_ASSERT(a_bk_zero_slope, out_valid_o && !slope_valid_o |-> slope_o == '0, "slope not zero when invalid")
  `BBSE_ASSERT(a_bk_box_order, out_valid_o |-> right_o >= left_o && bottom_o >= top_o, "box corners out of order")
  `BBSE_NEVER(a_bk_pop_busy, pop_o && out_valid_q, "new region taken while result pending")

endmodule

// ===== sv/blob_box_and_slope_extractor_unit.sv =====
// Blob box and slope extractor: accepts one outline point per cycle. The back
// end works on one region at a time: after its setup states it runs three
// divides and two square roots, one divide fewer when the slope denominator is
// zero. A two-region queue stalls input only on a last point while it is full.
// The back end takes a new region only once the last result has been taken.
// Asynchronous active-low reset clears counters, sums, queue and sequencer.
module blob_box_and_slope_extractor_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [bbse_pkg::CoordBits-1:0]  x_i,
  input  logic [bbse_pkg::CoordBits-1:0]  y_i,
  input  logic                            last_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [bbse_pkg::CoordBits-1:0]  left_o,
  output logic [bbse_pkg::CoordBits-1:0]  right_o,
  output logic [bbse_pkg::CoordBits-1:0]  top_o,
  output logic [bbse_pkg::CoordBits-1:0]  bottom_o,
  output logic [bbse_pkg::ScaleBits-1:0]  scaled_width_o,
  output logic [bbse_pkg::ScaleBits-1:0]  scaled_height_o,
  output logic signed [31:0]              slope_o,
  output logic                            slope_valid_o,
  output logic [bbse_pkg::CountBits-1:0]  point_count_o,
  output logic                            overflow_o
);

  logic              acc, push, full, pop, avail;
  bbse_pkg::region_t reg_in, reg_out;
  logic [31:0]       slope_bits;

  assign in_ready_o = ~(last_i & full);
  assign acc        = in_valid_i & in_ready_o;
  assign slope_o    = signed'(slope_bits);

  bbse_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .acc_i    (acc),
    .x_i      (x_i),
    .y_i      (y_i),
    .last_i   (last_i),
    .push_o   (push),
    .region_o (reg_in)
  );

  bbse_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (reg_in),
    .full_o  (full),
    .pop_i   (pop),
    .avail_o (avail),
    .data_o  (reg_out)
  );

  bbse_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .avail_i         (avail),
    .region_i        (reg_out),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .left_o          (left_o),
    .right_o         (right_o),
    .top_o           (top_o),
    .bottom_o        (bottom_o),
    .scaled_width_o  (scaled_width_o),
    .scaled_height_o (scaled_height_o),
    .slope_o         (slope_bits),
    .slope_valid_o   (slope_valid_o),
    .point_count_o   (point_count_o),
    .overflow_o      (overflow_o)
  );

endmodule

// ===== verif/blob_box_and_slope_extractor_unit_tb.sv =====
// Self-checking testbench for blob_box_and_slope_extractor_unit: drives outline
// points, predicts box, slope and scaled size per region, checks every result.
// Depends on bbse_pkg and the block RTL.
module blob_box_and_slope_extractor_unit_tb;

  localparam int unsigned CycleLimit = 4000000;
  localparam int unsigned DrainWait  = 600;

  typedef struct {
    logic [bbse_pkg::CoordBits-1:0] left;
    logic [bbse_pkg::CoordBits-1:0] right;
    logic [bbse_pkg::CoordBits-1:0] top;
    logic [bbse_pkg::CoordBits-1:0] bottom;
    logic [bbse_pkg::ScaleBits-1:0] sw;
    logic [bbse_pkg::ScaleBits-1:0] sh;
    logic [31:0]                    slope;
    logic                           slope_ok;
    logic [bbse_pkg::CountBits-1:0] cnt;
    logic                           ovf;
  } region_res_t;

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o, last_i;
  logic [bbse_pkg::CoordBits-1:0] x_i, y_i;
  logic out_valid_o, out_ready_i;
  logic [bbse_pkg::CoordBits-1:0] left_o, right_o, top_o, bottom_o;
  logic [bbse_pkg::ScaleBits-1:0] scaled_width_o, scaled_height_o;
  logic signed [31:0] slope_o;
  logic slope_valid_o, overflow_o;
  logic [bbse_pkg::CountBits-1:0] point_count_o;

  blob_box_and_slope_extractor_unit u_top (.*);

  // predictor state for the region being collected
  logic [bbse_pkg::CoordBits-1:0] bx_lo, bx_hi, by_lo, by_hi;
  longint unsigned pts, acc_x, acc_y, acc_xx, acc_xy;
  bit dropped;

  region_res_t region_q[$];
  int unsigned errors, cycles, sender_idle, recv_stall;

  always begin
    clk_i = 1'b1; #2;
    clk_i = 1'b0; #2;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("blob_box_and_slope_extractor_unit_tb failed");
      $finish;
    end
  end

  always @(posedge clk_i) out_ready_i <= ($urandom_range(99) >= recv_stall);

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [bbse_pkg::ScaleBits-1:0] scaled_dim(longint unsigned n,
                                                                longint unsigned p,
                                                                longint unsigned q);
    longint unsigned s;
    s = int_sqrt(((n * p) << 16) / q);
    return (s > 64'h7FFFFF) ? 23'h7FFFFF : s[bbse_pkg::ScaleBits-1:0];
  endfunction

  function automatic region_res_t close_region();
    region_res_t r;
    logic [127:0] a, b, mag, den, q;
    longint unsigned w, h;
    bit neg;
    w = bx_hi - bx_lo + 1;
    h = by_hi - by_lo + 1;
    a = 128'(pts) * 128'(acc_xy);
    b = 128'(acc_x) * 128'(acc_y);
    neg = a < b;
    mag = neg ? b - a : a - b;
    a = 128'(pts) * 128'(acc_xx);
    b = 128'(acc_x) * 128'(acc_x);
    den = (a >= b) ? a - b : '0;
    r.slope = '0;
    r.slope_ok = 1'b0;
    if (den != 0) begin
      q = (mag << 16) / den;
      r.slope_ok = 1'b1;
      if (neg) begin
        if (q > 128'h80000000) q = 128'h80000000;
        r.slope = -q[31:0];
      end else begin
        if (q > 128'h7FFFFFFF) q = 128'h7FFFFFFF;
        r.slope = q[31:0];
      end
    end
    r.left = bx_lo;
    r.right = bx_hi;
    r.top = by_lo;
    r.bottom = by_hi;
    r.sw = scaled_dim(pts, w, h);
    r.sh = scaled_dim(pts, h, w);
    r.cnt = pts[bbse_pkg::CountBits-1:0];
    r.ovf = dropped;
    return r;
  endfunction

  function automatic void clear_region();
    bx_lo = '0; bx_hi = '0; by_lo = '0; by_hi = '0;
    pts = 0; acc_x = 0; acc_y = 0; acc_xx = 0; acc_xy = 0;
    dropped = 0;
  endfunction

  function automatic void take_point(logic [bbse_pkg::CoordBits-1:0] px,
                                     logic [bbse_pkg::CoordBits-1:0] py, logic lst);
    if (pts >= bbse_pkg::MaxPoints) begin
      dropped = 1;
    end else begin
      if (pts == 0) begin
        bx_lo = px; bx_hi = px; by_lo = py; by_hi = py;
      end
      if (px < bx_lo) bx_lo = px;
      if (px > bx_hi) bx_hi = px;
      if (py < by_lo) by_lo = py;
      if (py > by_hi) by_hi = py;
      pts++;
      acc_x += px;
      acc_y += py;
      acc_xx += longint'(px) * px;
      acc_xy += longint'(px) * py;
    end
    if (lst) begin
      region_q.insert(region_q.size(), close_region());
      clear_region();
    end
  endfunction

  // one point transaction; valid stays up unless an idle gap follows
  task automatic send_point(logic [bbse_pkg::CoordBits-1:0] px,
                            logic [bbse_pkg::CoordBits-1:0] py, logic lst);
    in_valid_i <= 1'b1;
    x_i <= px;
    y_i <= py;
    last_i <= lst;
    do @(posedge clk_i); while (!in_ready_o);
    take_point(px, py, lst);
    if ($urandom_range(99) < sender_idle) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < sender_idle);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (region_q.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    region_res_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (region_q.size() == 0) begin
        $display("%0t unexpected result transaction", $time);
        errors++;
      end else begin
        e = region_q.pop_front();
        if ({left_o, right_o, top_o, bottom_o} != {e.left, e.right, e.top, e.bottom}) begin
          $display("%0t box exp %0d %0d %0d %0d got %0d %0d %0d %0d", $time, e.left,
                   e.right, e.top, e.bottom, left_o, right_o, top_o, bottom_o);
          errors++;
        end
        if (scaled_width_o != e.sw || scaled_height_o != e.sh) begin
          $display("%0t scaled exp %0d %0d got %0d %0d", $time, e.sw, e.sh,
                   scaled_width_o, scaled_height_o);
          errors++;
        end
        if (slope_o != e.slope || slope_valid_o != e.slope_ok) begin
          $display("%0t slope exp %0d/%0b got %0d/%0b", $time, $signed(e.slope),
                   e.slope_ok, slope_o, slope_valid_o);
          errors++;
        end
        if (point_count_o != e.cnt || overflow_o != e.ovf) begin
          $display("%0t count exp %0d/%0b got %0d/%0b", $time, e.cnt, e.ovf,
                   point_count_o, overflow_o);
          errors++;
        end
      end
    end
  end

  task automatic test_single_points();
    send_point(12'd0, 12'd0, 1'b1);
    send_point(12'hFFF, 12'hFFF, 1'b1);
    send_point(12'hA5A, 12'h5A5, 1'b1);
  endtask

  task automatic test_vertical_line();
    send_point(12'd100, 12'd0, 1'b0);
    send_point(12'd100, 12'hFFF, 1'b0);
    send_point(12'd100, 12'd7, 1'b1);
  endtask

  task automatic test_corners();
    send_point(12'd0, 12'd0, 1'b0);
    send_point(12'hFFF, 12'd0, 1'b0);
    send_point(12'd0, 12'hFFF, 1'b0);
    send_point(12'hFFF, 12'hFFF, 1'b1);
  endtask

  task automatic test_slopes();
    // steepest rising and falling lines, a flat one, then a shallow falling one
    send_point(12'd0, 12'd0, 1'b0);
    send_point(12'd1, 12'hFFF, 1'b1);
    send_point(12'd0, 12'hFFF, 1'b0);
    send_point(12'd1, 12'd0, 1'b1);
    send_point(12'd0, 12'd50, 1'b0);
    send_point(12'hFFF, 12'd50, 1'b0);
    send_point(12'd2048, 12'd50, 1'b1);
    send_point(12'hFFF, 12'd0, 1'b0);
    send_point(12'd0, 12'd1, 1'b1);
  endtask

  task automatic test_random_regions(int unsigned n_items);
    int unsigned sent, len, mode;
    logic [bbse_pkg::CoordBits-1:0] bx, by, span, px, py;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(9) < 8) ? $urandom_range(1, 24) : $urandom_range(25, 200);
      mode = $urandom_range(3);
      bx = 12'($urandom);
      by = 12'($urandom);
      span = 12'($urandom_range(1, 255));
      for (int i = 0; i < len; i++) begin
        case (mode)
          0: begin px = 12'($urandom); py = 12'($urandom); end
          1: begin px = bx; py = 12'($urandom); end
          default: begin
            px = bx + 12'($urandom_range(0, span));
            py = by + 12'($urandom_range(0, span));
          end
        endcase
        send_point(px, py, i == len - 1);
      end
      sent += len;
    end
  endtask

  initial begin
    errors = 0;
    cycles = 0;
    sender_idle = 0;
    recv_stall = 0;
    clear_region();
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    x_i = '0;
    y_i = '0;
    last_i = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_single_points();
    test_vertical_line();
    test_corners();
    test_slopes();
    wait_drained();

    test_random_regions(490);
    sender_idle = 72;
    recv_stall = 0;
    test_random_regions(490);
    wait_drained();
    sender_idle = 0;
    recv_stall = 72;
    test_random_regions(490);
    sender_idle = 17;
    recv_stall = 17;
    test_random_regions(490);

    wait_drained();
    repeat (DrainWait) @(posedge clk_i);
    if (errors == 0 && region_q.size() == 0)
      $display("blob_box_and_slope_extractor_unit_tb passed");
    else
      $display("blob_box_and_slope_extractor_unit_tb failed");
    $finish;
  end

endmodule
